@@ src/molding_cycle_sequencer_macros.svh @@
`ifndef MOLDING_CYCLE_SEQUENCER_MACROS_SVH
`define MOLDING_CYCLE_SEQUENCER_MACROS_SVH

// same-cycle implication, dropped while reset is low
`define MCS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("molding_cycle_sequencer: same-cycle check failed");

// next-cycle implication, dropped while reset is low
`define MCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("molding_cycle_sequencer: next-cycle check failed");

`endif

@@ src/mcs_pkg.sv @@
package mcs_pkg;

    localparam int AVG_DEPTH = 10;
    localparam int TEMP_W    = 11;
    localparam int DUTY_W    = 8;
    localparam int TIME_W    = 32;
    localparam int BLINK_W   = 16;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W     = $clog2(((1 << TEMP_W) - 1) * AVG_DEPTH + 1);
    localparam int AVG_LOG   = $clog2(AVG_DEPTH);
    localparam int AVG_SHIFT = SUM_W + AVG_LOG;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(AVG_DEPTH - 1);
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    localparam logic [2:0] PHASE_CODE_STANDBY = 3'd0;
    localparam logic [2:0] PHASE_CODE_HEAT    = 3'd1;
    localparam logic [2:0] PHASE_CODE_INSERT  = 3'd2;
    localparam logic [2:0] PHASE_CODE_MELT    = 3'd3;
    localparam logic [2:0] PHASE_CODE_INJECT  = 3'd4;

    typedef enum logic [2:0] {
        REG_NOZZLE_TARGET  = 3'd0,
        REG_BARREL_TARGET  = 3'd1,
        REG_HEATER_DUTY    = 3'd2,
        REG_INSERT_TIME    = 3'd3,
        REG_MELT_TIME      = 3'd4,
        REG_INJECT_TIME    = 3'd5,
        REG_BLINK_PERIOD   = 3'd6,
        REG_WARM_THRESHOLD = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [TEMP_W-1:0]  nozzle_target;
        logic [TEMP_W-1:0]  barrel_target;
        logic [DUTY_W-1:0]  heater_duty;
        logic [TIME_W-1:0]  insert_time;
        logic [TIME_W-1:0]  melt_time;
        logic [TIME_W-1:0]  inject_time;
        logic [BLINK_W-1:0] blink_period;
        logic [TEMP_W-1:0]  warm_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        nozzle_target:  TEMP_W'(220),
        barrel_target:  TEMP_W'(210),
        heater_duty:    DUTY_W'(210),
        insert_time:    TIME_W'(10000),
        melt_time:      TIME_W'(1200000),
        inject_time:    TIME_W'(30000),
        blink_period:   BLINK_W'(500),
        warm_threshold: TEMP_W'(40)
    };

    typedef struct packed {
        logic [TEMP_W-1:0] nozzle;
        logic [TEMP_W-1:0] barrel;
    } sample_pair_t;

endpackage

@@ src/mcs_cfg_regs.sv @@
module mcs_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcs_pkg::PADDR_W-1:0]   paddr,
    input  logic [mcs_pkg::PDATA_W-1:0]   pwdata,
    output logic [mcs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output mcs_pkg::cfg_t                 cfg
);
    import mcs_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;

    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_NOZZLE_TARGET:  cfg_next.nozzle_target  = pwdata[TEMP_W-1:0];
                REG_BARREL_TARGET:  cfg_next.barrel_target  = pwdata[TEMP_W-1:0];
                REG_HEATER_DUTY:    cfg_next.heater_duty    = pwdata[DUTY_W-1:0];
                REG_INSERT_TIME:    cfg_next.insert_time    = pwdata[TIME_W-1:0];
                REG_MELT_TIME:      cfg_next.melt_time      = pwdata[TIME_W-1:0];
                REG_INJECT_TIME:    cfg_next.inject_time    = pwdata[TIME_W-1:0];
                REG_BLINK_PERIOD:   cfg_next.blink_period   = pwdata[BLINK_W-1:0];
                REG_WARM_THRESHOLD: cfg_next.warm_threshold = pwdata[TEMP_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NOZZLE_TARGET:  prdata = PDATA_W'(cfg_reg.nozzle_target);
            REG_BARREL_TARGET:  prdata = PDATA_W'(cfg_reg.barrel_target);
            REG_HEATER_DUTY:    prdata = PDATA_W'(cfg_reg.heater_duty);
            REG_INSERT_TIME:    prdata = PDATA_W'(cfg_reg.insert_time);
            REG_MELT_TIME:      prdata = PDATA_W'(cfg_reg.melt_time);
            REG_INJECT_TIME:    prdata = PDATA_W'(cfg_reg.inject_time);
            REG_BLINK_PERIOD:   prdata = PDATA_W'(cfg_reg.blink_period);
            REG_WARM_THRESHOLD: prdata = PDATA_W'(cfg_reg.warm_threshold);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/mcs_window.sv @@
module mcs_window (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [mcs_pkg::TEMP_W-1:0]   nozzle_sample,
    input  logic [mcs_pkg::TEMP_W-1:0]   barrel_sample,
    output logic                         done,
    output logic [mcs_pkg::TEMP_W-1:0]   nozzle_avg,
    output logic [mcs_pkg::TEMP_W-1:0]   barrel_avg
);
    import mcs_pkg::*;

    sample_pair_t      win_mem [AVG_DEPTH];
    sample_pair_t      rd_data_reg;
    sample_pair_t      new_reg;
    sample_pair_t      old_pair;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              full_reg, full_next;
    logic [SUM_W-1:0]  nsum_reg, nsum_next;
    logic [SUM_W-1:0]  bsum_reg, bsum_next;
    logic [PROD_W-1:0] nprod_reg, bprod_reg;
    logic [TEMP_W-1:0] navg_reg, bavg_reg;
    logic              rd_stage_reg, sum_stage_reg, mul_stage_reg, done_reg;

    // entries not yet written since reset read as zero
    assign old_pair  = full_reg ? rd_data_reg : '0;
    assign nsum_next = nsum_reg - SUM_W'(old_pair.nozzle) + SUM_W'(new_reg.nozzle);
    assign bsum_next = bsum_reg - SUM_W'(old_pair.barrel) + SUM_W'(new_reg.barrel);
    assign idx_next  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign full_next = full_reg | (idx_reg == IDX_LAST);

    always_ff @(posedge aclk) begin
        if (start) begin
            rd_data_reg <= win_mem[idx_reg];
        end
        if (rd_stage_reg) begin
            win_mem[idx_reg] <= new_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            new_reg <= '{nozzle: nozzle_sample, barrel: barrel_sample};
        end
        if (sum_stage_reg) begin
            nprod_reg <= PROD_W'(nsum_reg) * PROD_W'(AVG_RECIP);
            bprod_reg <= PROD_W'(bsum_reg) * PROD_W'(AVG_RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_stage_reg  <= 1'b0;
            sum_stage_reg <= 1'b0;
            mul_stage_reg <= 1'b0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
            full_reg      <= 1'b0;
            nsum_reg      <= '0;
            bsum_reg      <= '0;
            navg_reg      <= '0;
            bavg_reg      <= '0;
        end else begin
            rd_stage_reg  <= start;
            sum_stage_reg <= rd_stage_reg;
            mul_stage_reg <= sum_stage_reg;
            done_reg      <= mul_stage_reg;
            if (rd_stage_reg) begin
                idx_reg  <= idx_next;
                full_reg <= full_next;
                nsum_reg <= nsum_next;
                bsum_reg <= bsum_next;
            end
            if (mul_stage_reg) begin
                navg_reg <= nprod_reg[AVG_SHIFT +: TEMP_W];
                bavg_reg <= bprod_reg[AVG_SHIFT +: TEMP_W];
            end
        end
    end

    assign done       = done_reg;
    assign nozzle_avg = navg_reg;
    assign barrel_avg = bavg_reg;

endmodule

@@ src/molding_cycle_sequencer.sv @@
// Molding cycle sequencer: one tick beat in on s_, one result beat out on m_. The sample
// window memory is read at the accepting edge. Then the running sums are updated and the
// new samples written back, the reciprocal multiply is done and the product is scaled to
// the averages. The averages pass to the sequencer, which forms phase, drives and LED and
// loads the output register once m_valid is low or m_ready is high; no new tick is taken
// before that load. s_ready is high between ticks, and a result held in the output
// register does not stop the next tick being taken. The window needs no clearing pass
// after reset: a fill flag makes the entries not yet written count as zero.
`include "molding_cycle_sequencer_macros.svh"

module molding_cycle_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcs_pkg::PADDR_W-1:0]   paddr,
    input  logic [mcs_pkg::PDATA_W-1:0]   pwdata,
    output logic [mcs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mcs_pkg::TIME_W-1:0]    s_time_ms,
    input  logic [mcs_pkg::TEMP_W-1:0]    s_nozzle_sample,
    input  logic [mcs_pkg::TEMP_W-1:0]    s_barrel_sample,
    input  logic                          s_start_cycle,
    input  logic                          s_cancel_cycle,
    input  logic                          s_heat_toggle,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_phase_now,
    output logic [mcs_pkg::DUTY_W-1:0]    m_nozzle_drive,
    output logic [mcs_pkg::DUTY_W-1:0]    m_barrel_drive,
    output logic                          m_heater_enabled,
    output logic                          m_door_open,
    output logic                          m_piston_on,
    output logic                          m_led_on,
    output logic [mcs_pkg::TEMP_W-1:0]    m_nozzle_average,
    output logic [mcs_pkg::TEMP_W-1:0]    m_barrel_average
);
    import mcs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_AVG  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    typedef enum logic [4:0] {
        PH_STANDBY = 5'b00001,
        PH_HEAT    = 5'b00010,
        PH_INSERT  = 5'b00100,
        PH_MELT    = 5'b01000,
        PH_INJECT  = 5'b10000
    } phase_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_STANDBY: code = PHASE_CODE_STANDBY;
            PH_HEAT:    code = PHASE_CODE_HEAT;
            PH_INSERT:  code = PHASE_CODE_INSERT;
            PH_MELT:    code = PHASE_CODE_MELT;
            PH_INJECT:  code = PHASE_CODE_INJECT;
            default:    code = PHASE_CODE_STANDBY;
        endcase
        return code;
    endfunction

    cfg_t              cfg;
    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next, phase_ev;
    logic [TIME_W-1:0] phase_start_reg, phase_start_next;
    logic              heat_flag_reg, heat_flag_next, heat_ev, heat_step;
    logic              led_level_reg, led_level_next;
    logic [TIME_W-1:0] led_mark_reg, led_mark_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] elapsed;
    logic              m_valid_reg, m_valid_next;

    logic [2:0]        phase_out_reg;
    logic [DUTY_W-1:0] ndrive_reg, bdrive_reg, ndrive, bdrive;
    logic              heat_out_reg, door_reg, piston_reg, led_out_reg;
    logic [TEMP_W-1:0] navg_out_reg, bavg_out_reg;

    logic              accept, out_load, out_stall, avg_done, reached, heat_fin;
    logic [TEMP_W-1:0] navg, bavg;

    mcs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcs_window u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (accept),
        .nozzle_sample (s_nozzle_sample),
        .barrel_sample (s_barrel_sample),
        .done          (avg_done),
        .nozzle_avg    (navg),
        .barrel_avg    (bavg)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign out_stall = (state_reg == ST_OUT) && m_valid_reg && !m_ready;

    // events and phase step, judged on the averages from the previous tick
    always_comb begin
        phase_ev = phase_reg;
        heat_ev  = heat_flag_reg;
        if (phase_reg == PH_STANDBY) begin
            if (s_heat_toggle) begin
                heat_ev = ~heat_flag_reg;
            end
            if (s_start_cycle) begin
                phase_ev = PH_HEAT;
            end
        end else if (s_cancel_cycle) begin
            phase_ev = PH_STANDBY;
        end

        elapsed          = s_time_ms - phase_start_reg;
        phase_next       = phase_ev;
        phase_start_next = phase_start_reg;
        heat_step        = heat_ev;
        unique case (phase_ev)
            PH_STANDBY: begin
                phase_start_next = s_time_ms;
            end
            PH_HEAT: begin
                heat_step = 1'b1;
                if (navg >= cfg.nozzle_target && bavg >= cfg.barrel_target) begin
                    phase_next       = PH_INSERT;
                    phase_start_next = s_time_ms;
                end
            end
            PH_INSERT: begin
                if (elapsed > cfg.insert_time) begin
                    phase_next       = PH_MELT;
                    phase_start_next = s_time_ms;
                end
            end
            PH_MELT: begin
                if (elapsed > cfg.melt_time) begin
                    phase_next       = PH_INJECT;
                    phase_start_next = s_time_ms;
                end
            end
            PH_INJECT: begin
                if (elapsed > cfg.inject_time) begin
                    phase_next       = PH_STANDBY;
                    phase_start_next = s_time_ms;
                    heat_step        = 1'b0;
                end
            end
            default: begin
                phase_next       = PH_STANDBY;
                phase_start_next = s_time_ms;
            end
        endcase
    end

    // heaters and LED on the new averages
    always_comb begin
        ndrive   = '0;
        bdrive   = '0;
        reached  = 1'b0;
        heat_fin = heat_flag_reg;
        if (heat_flag_reg) begin
            if (navg < cfg.nozzle_target) begin
                ndrive = cfg.heater_duty;
            end else begin
                reached = 1'b1;
            end
            if (bavg < cfg.barrel_target) begin
                bdrive = cfg.heater_duty;
            end else begin
                reached = 1'b1;
            end
            if (reached && phase_reg == PH_STANDBY) begin
                heat_fin = 1'b0;
            end
        end

        led_level_next = led_level_reg;
        led_mark_next  = led_mark_reg;
        if (phase_reg != PH_STANDBY) begin
            if (time_reg - led_mark_reg > TIME_W'(cfg.blink_period)) begin
                led_level_next = ~led_level_reg;
                led_mark_next  = time_reg;
            end
        end else begin
            led_level_next = (navg > cfg.warm_threshold) || (bavg > cfg.warm_threshold);
        end
    end

    always_comb begin
        state_next     = state_reg;
        heat_flag_next = heat_flag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    heat_flag_next = heat_step;
                    state_next     = ST_AVG;
                end
            end
            ST_AVG: begin
                if (avg_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    heat_flag_next = heat_fin;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_STANDBY;
            phase_start_reg <= '0;
            heat_flag_reg   <= 1'b0;
            led_level_reg   <= 1'b0;
            led_mark_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            heat_flag_reg <= heat_flag_next;
            m_valid_reg   <= m_valid_next;
            if (accept) begin
                phase_reg       <= phase_next;
                phase_start_reg <= phase_start_next;
            end
            if (out_load) begin
                led_level_reg <= led_level_next;
                led_mark_reg  <= led_mark_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            time_reg <= s_time_ms;
        end
        if (out_load) begin
            phase_out_reg <= phase_code(phase_reg);
            ndrive_reg    <= ndrive;
            bdrive_reg    <= bdrive;
            heat_out_reg  <= heat_fin;
            door_reg      <= (phase_reg == PH_INSERT);
            piston_reg    <= (phase_reg == PH_INJECT);
            led_out_reg   <= led_level_next;
            navg_out_reg  <= navg;
            bavg_out_reg  <= bavg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_phase_now      = phase_out_reg;
    assign m_nozzle_drive   = ndrive_reg;
    assign m_barrel_drive   = bdrive_reg;
    assign m_heater_enabled = heat_out_reg;
    assign m_door_open      = door_reg;
    assign m_piston_on      = piston_reg;
    assign m_led_on         = led_out_reg;
    assign m_nozzle_average = navg_out_reg;
    assign m_barrel_average = bavg_out_reg;

    `MCS_ASSERT_NEXT(a_accept_to_avg, aclk, aresetn, accept, state_reg == ST_AVG)
    `MCS_ASSERT_IMPL(a_done_in_avg, aclk, aresetn, avg_done, state_reg == ST_AVG)
    `MCS_ASSERT_NEXT(a_hold_result, aclk, aresetn, out_stall, state_reg == ST_OUT)

endmodule
